// ===== rtl/are_pkg.sv =====
// Package: shared types and constants for the adaptive range encoder.
package are_pkg;
  localparam int unsigned NumEntries = 257;
  localparam int unsigned IdxW = 9;
  localparam int unsigned CntW = 17;
  localparam logic [31:0] HalfLimit = 32'h0001_0000;
  localparam logic [7:0] MaxSym = 8'(NumEntries - 2);

  localparam logic ActEncode = 1'b0;
  localparam logic ActFinish = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last;
    logic       stream_end;
  } out_item_t;
endpackage

// ===== rtl/are_front.sv =====
// Front end: accepts requests, saturates symbols, drops items after finish, queues them.
module are_front import are_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output in_item_t q_data
);
  in_item_t   mem [2];
  logic [1:0] count;
  logic       wr_ptr, rd_ptr, done;
  logic       push, pop;
  in_item_t   item;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_data   = mem[rd_ptr];
  assign pop      = q_valid && q_ready;
  assign push     = in_valid && in_ready && !done;

  always_comb begin
    item = in_data;
    if (in_data.symbol > MaxSym) item.symbol = MaxSym;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item;
    if (rst) begin
      count <= '0; wr_ptr <= 1'b0; rd_ptr <= 1'b0; done <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
      if (in_valid && in_ready && in_data.action == ActFinish) done <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) $past(done) |-> !push)
    else $error("item queued after finish");
endmodule

// ===== rtl/are_back.sv =====
// Back end: table update, iterative divide, rescale sweep and byte output.
module are_back import are_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  in_item_t  q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  localparam logic [3:0] SInit = 4'd0, SIdle = 4'd1, SRd0 = 4'd2, SRd1 = 4'd3,
                         SDiv = 4'd4, SMul = 4'd5, SInc = 4'd6, SHalf = 4'd7,
                         SNorm = 4'd8, SEmit = 4'd9, SFlush = 4'd10;

  logic [CntW-1:0] tbl [NumEntries];
  logic [CntW-1:0] rd_data;
  logic [IdxW-1:0] rd_addr, idx, wr_addr;
  logic [CntW-1:0] wr_data;
  logic            wr_en;

  logic [3:0]  state;
  logic [31:0] low, range;
  logic [7:0]  sym;
  logic [CntW-1:0] total, base, cnt, prev;
  logic [31:0] quot, rem;
  logic [5:0]  step;
  logic [2:0]  nout;
  logic        flush;
  logic [32:0] trial;
  logic [CntW-1:0] half_v;

  // one-port style table: read registered, single write
  always_ff @(posedge clk) begin
    if (wr_en) tbl[wr_addr] <= wr_data;
    rd_data <= tbl[rd_addr];
  end

  assign q_ready = (state == SIdle);
  assign trial   = {rem, quot[31]} - {16'd0, total};
  assign half_v  = (rd_data >> 1) <= prev ? prev + 1'b1 : rd_data >> 1;

  always_comb begin
    rd_addr = idx; wr_en = 1'b0; wr_addr = idx; wr_data = '0;
    case (state)
      SInit: begin wr_en = 1'b1; wr_data = CntW'(idx); end
      SIdle: rd_addr = IdxW'(q_data.symbol);
      SInc:  if (step != 0) begin
        wr_en = 1'b1; wr_addr = idx - 1'b1; wr_data = rd_data + 1'b1;
      end
      SHalf: if (step != 0) begin
        wr_en = 1'b1; wr_addr = idx - 1'b1; wr_data = half_v;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SInit; idx <= '0; low <= '0; range <= '1;
      total <= CntW'(NumEntries - 1); out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        SInit: begin
          idx <= idx + 1'b1;
          if (idx == IdxW'(NumEntries - 1)) state <= SIdle;
        end
        SIdle: if (q_valid) begin
          sym <= q_data.symbol; nout <= '0;
          if (q_data.action == ActFinish) begin
            flush <= 1'b1; state <= SEmit;
          end else begin
            flush <= 1'b0; idx <= IdxW'(q_data.symbol) + 1'b1; state <= SRd0;
          end
        end
        SRd0: begin base <= rd_data; state <= SRd1; end
        SRd1: begin
          cnt <= rd_data - base; quot <= range; rem <= '0; step <= '0;
          state <= SDiv;
        end
        SDiv: begin // restoring divide, one bit a cycle
          if (!trial[32]) begin
            rem <= trial[31:0]; quot <= {quot[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], quot[31]}; quot <= {quot[30:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == 6'd31) state <= SMul;
        end
        SMul: begin
          low <= low + quot * {15'd0, base};
          range <= quot * {15'd0, cnt};
          idx <= IdxW'(sym) + 1'b1; step <= '0; state <= SInc;
        end
        SInc: begin // read-modify-write sweep over entries above the symbol
          step <= 6'd1;
          if (step != 0 && idx - 1'b1 == IdxW'(NumEntries - 1)) begin
            total <= rd_data + 1'b1;
            if (rd_data + 1'b1 >= CntW'(HalfLimit)) begin
              idx <= IdxW'(1); step <= '0; state <= SHalf;
            end else state <= SNorm;
          end else idx <= idx + 1'b1;
        end
        SHalf: begin
          if (step == 0) begin
            prev <= CntW'(0); step <= 6'd1; idx <= idx + 1'b1;
          end else begin
            prev <= half_v;
            if (idx - 1'b1 == IdxW'(NumEntries - 1)) begin
              total <= half_v; state <= SNorm;
            end else idx <= idx + 1'b1;
          end
        end
        SNorm: begin
          if (range < HalfLimit && nout < 3'd4) begin
            if (low[23:16] == 8'hff && range + {16'd0, low[15:0]} >= HalfLimit)
              range <= HalfLimit - {16'd0, low[15:0]};
            state <= SEmit;
          end else state <= SIdle;
        end
        SEmit: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          out_data.code_byte <= low[31:24];
          low <= low << 8; nout <= nout + 1'b1;
          if (flush) begin
            out_data.last <= (nout == 3'd3); out_data.stream_end <= (nout == 3'd3);
            if (nout == 3'd3) state <= SIdle;
          end else begin
            range <= range << 8;
            out_data.stream_end <= 1'b0;
            out_data.last <= !((range << 8) < HalfLimit && nout < 3'd3);
            state <= SNorm;
          end
        end
        default: state <= SIdle;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready)
    |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");
  assert property (@(posedge clk) disable iff (rst) q_ready |-> state == SIdle)
    else $error("request taken while busy");
  assert property (@(posedge clk) disable iff (rst) out_data.stream_end && out_valid
    |-> out_data.last)
    else $error("stream end without last");
endmodule

// ===== rtl/adaptive_range_encoder.sv =====
// Top level of the adaptive order-0 range encoder.
// Input channel (in_valid/in_ready/in_data) takes requests: action encode
// with a byte symbol, or finish. Output channel (out_valid/out_ready/out_data)
// gives code bytes with last on the final byte of each request and
// stream_end on the fourth flushed byte.
// A two-entry queue sits between the front end and the back end.
// An encode does two table reads, a bit-serial divide and one multiply, then
// a read-modify-write sweep over each table entry above the symbol (up to
// 256), plus a rescale sweep that halves the counts when the total reaches
// HalfLimit, and then emits its bytes.
// Requests after finish are dropped.
// After reset the table is loaded entry by entry; requests queue meanwhile.
// When the receiver stalls, the output register holds its byte and the back
// end waits; the queue fills and in_ready falls.
module adaptive_range_encoder import are_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  logic     q_valid, q_ready;
  in_item_t q_data;

  are_front u_front (.clk, .rst, .in_valid, .in_ready, .in_data,
                     .q_valid, .q_ready, .q_data);
  are_back u_back (.clk, .rst, .q_valid, .q_ready, .q_data,
                   .out_valid, .out_ready, .out_data);
endmodule
